// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define H2R_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define H2R_ASSERT_NEVER(name, expr, msg) \
  `H2R_ASSERT(name, !(expr), msg)

`endif

// ----- src/h2r_pkg.sv -----
// ----------------------------------------------------------------------------
// h2r_pkg
// Types and constants shared by the HSL to RGB converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegSaturation = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLightness  = 1'b1;

  // Fixed-point constants
  localparam logic [16:0] Q16One    = 17'h10000;
  localparam logic [16:0] DegFull   = 17'd360;
  localparam logic [8:0]  SectorDeg = 9'd60;

  // Bias that makes the integer degree part non-negative (92 * 360)
  localparam logic [16:0] HueBias = 17'd33120;

  // Reciprocals for the divisions by 360 and by 60 (rounded down)
  localparam logic [15:0] Recip360      = 16'd46603;
  localparam int unsigned Recip360Shift = 24;
  localparam logic [22:0] Recip60       = 23'd4473924;
  localparam int unsigned Recip60Shift  = 28;

  // Classified hue: sector, degrees within the sector, fraction of a degree
  typedef struct packed {
    logic [2:0]  sector;
    logic [5:0]  rem;
    logic [15:0] frac;
  } h2r_item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [7:0] sat;
    logic [7:0] light;
  } h2r_cfg_t;

  // Widen an 8-bit fraction to Q16.16: floor(v * 65536 / 255)
  function automatic logic [16:0] widen8(input logic [7:0] v);
    logic [16:0] res;
    if (v == 8'hFF) begin
      res = Q16One;
    end else begin
      res = {1'b0, v, v};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/h2r_fifo.sv -----
// ----------------------------------------------------------------------------
// h2r_fifo
// Small register-based first-in first-out queue with registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/h2r_front.sv -----
// ----------------------------------------------------------------------------
// h2r_front
// Accepts hue requests, wraps them modulo 360 degrees and splits the
// result into sector, degrees within the sector and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_front import h2r_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  input  wire logic signed [31:0] hue_i,
  output      logic               full,
  output      h2r_item_t          item_o,
  output      logic               item_push_o,
  input  wire logic               queue_full_i
);

  logic        valid_q, valid_d;
  logic [16:0] deg_q;
  logic [7:0]  quot_q;
  logic [15:0] frac_q;

  logic [16:0] deg_biased;
  logic [32:0] quot_prod;
  logic        accept;
  logic [16:0] quot_mul;
  logic [16:0] deg_rem;
  logic [8:0]  deg_wrap;
  logic [2:0]  sector;
  logic [8:0]  sector_base;

  // Integer degrees made non-negative, then a first estimate of the quotient
  assign deg_biased = {hue_i[31], hue_i[31:16]} + HueBias;
  assign quot_prod  = 33'(deg_biased) * 33'(Recip360);

  assign full        = valid_q && queue_full_i;
  assign accept      = push && !full;
  assign item_push_o = valid_q && !queue_full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      deg_q  <= deg_biased;
      quot_q <= quot_prod[Recip360Shift +: 8];
      frac_q <= hue_i[15:0];
    end
  end

  // Correct the remainder: the estimate is low by at most one
  assign quot_mul = 17'(quot_q) * DegFull;
  assign deg_rem  = deg_q - quot_mul;
  assign deg_wrap = (deg_rem >= DegFull) ? 9'(deg_rem - DegFull) : deg_rem[8:0];

  // Classify into 60-degree sectors
  always_comb begin
    if (deg_wrap >= 9'd300) begin
      sector = 3'd5;
    end else if (deg_wrap >= 9'd240) begin
      sector = 3'd4;
    end else if (deg_wrap >= 9'd180) begin
      sector = 3'd3;
    end else if (deg_wrap >= 9'd120) begin
      sector = 3'd2;
    end else if (deg_wrap >= 9'd60) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
  end

  assign sector_base = 9'(9'(sector) * SectorDeg);

  assign item_o.sector = sector;
  assign item_o.rem    = 6'(deg_wrap - sector_base);
  assign item_o.frac   = frac_q;

endmodule

`default_nettype wire

// ----- src/h2r_back.sv -----
// ----------------------------------------------------------------------------
// h2r_back
// Computes chroma, second component and offset for a classified hue and
// turns the three channels into clamped 8-bit values.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r_back import h2r_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire h2r_cfg_t  cfg_i,
  input  wire h2r_item_t item_i,
  input  wire logic      item_empty_i,
  output      logic      item_pop_o,
  output      logic      rgb_push_o,
  output      logic [7:0] red_o,
  output      logic [7:0] green_o,
  output      logic [7:0] blue_o,
  input  wire logic      rgb_full_i
);

  // Q16.16 to 8 bits: (v * 255) >> 16, clamped
  function automatic logic [7:0] narrow8(input logic [17:0] v);
    logic [25:0] prod;
    logic [9:0]  t;
    prod = {v, 8'b0} - 26'(v);
    t    = prod[25:16];
    return (t > 10'd255) ? 8'hFF : t[7:0];
  endfunction

  logic advance;

  // Stage C
  logic        c_valid_q;
  logic [2:0]  c_sector_q;
  logic [21:0] c_w_q;
  logic [15:0] c_t_q;
  logic [16:0] c_chroma_q;
  logic [16:0] c_light_q;

  // Stage D
  logic        d_valid_q;
  logic [2:0]  d_sector_q;
  logic [16:0] d_f_q;
  logic [16:0] d_chroma_q;
  logic [16:0] d_m_q;

  // Stage E
  logic        e_valid_q;
  logic [2:0]  e_sector_q;
  logic [16:0] e_x_q;
  logic [16:0] e_chroma_q;
  logic [16:0] e_m_q;

  logic [21:0] w;
  logic [44:0] t_prod;
  logic [16:0] sat16, light16;
  logic [17:0] two_l;
  logic [16:0] l_dist;
  logic [16:0] one_minus;
  logic [33:0] chroma_prod;

  logic [21:0] t_mul;
  logic [21:0] t_rem;
  logic [16:0] t_fix;
  logic [16:0] f;
  logic [16:0] m;

  logic [33:0] x_prod;
  logic [16:0] r_lin, g_lin, b_lin;

  // Hold the pipeline while the last stage cannot drain
  assign advance    = !(e_valid_q && rgb_full_i);
  assign item_pop_o = advance && !item_empty_i;
  assign rgb_push_o = e_valid_q && !rgb_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (advance) begin
      c_valid_q <= item_pop_o;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  // Stage C: position inside the sector over 60, and chroma
  assign w      = {item_i.rem, item_i.frac};
  assign t_prod = 45'(w) * 45'(Recip60);

  assign sat16     = widen8(cfg_i.sat);
  assign light16   = widen8(cfg_i.light);
  assign two_l     = {light16, 1'b0};
  assign l_dist    = (two_l >= 18'(Q16One)) ? 17'(two_l - 18'(Q16One))
                                            : 17'(18'(Q16One) - two_l);
  assign one_minus = Q16One - l_dist;
  assign chroma_prod = 34'(one_minus) * 34'(sat16);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_sector_q <= item_i.sector;
      c_w_q      <= w;
      c_t_q      <= t_prod[Recip60Shift +: 16];
      c_chroma_q <= chroma_prod[32:16];
      c_light_q  <= light16;
    end
  end

  // Stage D: correct the quotient, fold into a triangle, compute offset
  assign t_mul = 22'(c_t_q) * 22'(SectorDeg);
  assign t_rem = c_w_q - t_mul;
  assign t_fix = (t_rem >= 22'(SectorDeg)) ? 17'(c_t_q) + 17'd1 : 17'(c_t_q);
  assign f     = c_sector_q[0] ? Q16One - t_fix : t_fix;
  assign m     = c_light_q - {1'b0, c_chroma_q[16:1]};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      d_sector_q <= c_sector_q;
      d_f_q      <= f;
      d_chroma_q <= c_chroma_q;
      d_m_q      <= m;
    end
  end

  // Stage E: second component
  assign x_prod = 34'(d_chroma_q) * 34'(d_f_q);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      e_sector_q <= d_sector_q;
      e_x_q      <= x_prod[32:16];
      e_chroma_q <= d_chroma_q;
      e_m_q      <= d_m_q;
    end
  end

  // Order the channels by sector
  always_comb begin
    unique case (e_sector_q)
      3'd0: begin
        r_lin = e_chroma_q; g_lin = e_x_q;      b_lin = '0;
      end
      3'd1: begin
        r_lin = e_x_q;      g_lin = e_chroma_q; b_lin = '0;
      end
      3'd2: begin
        r_lin = '0;         g_lin = e_chroma_q; b_lin = e_x_q;
      end
      3'd3: begin
        r_lin = '0;         g_lin = e_x_q;      b_lin = e_chroma_q;
      end
      3'd4: begin
        r_lin = e_x_q;      g_lin = '0;         b_lin = e_chroma_q;
      end
      default: begin
        r_lin = e_chroma_q; g_lin = '0;         b_lin = e_x_q;
      end
    endcase
  end

  // Add offset and narrow to 8 bits
  assign red_o   = narrow8(18'(r_lin) + 18'(e_m_q));
  assign green_o = narrow8(18'(g_lin) + 18'(e_m_q));
  assign blue_o  = narrow8(18'(b_lin) + 18'(e_m_q));

endmodule

`default_nettype wire

// ----- src/hsl_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Fixed-point HSL to RGB color converter with queue-style channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive hue_i (signed Q16.16 degrees, any value) and raise
//   push; the request is taken at a clock edge where full is low.
//   Output channel: while empty is low, red_o/green_o/blue_o show the oldest
//   result; raise pop to take it.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 saturation, 1 lightness) at the clock edge; write only while idle.
//   Path: front register, middle queue, back stages C, D and E, output queue.
//   Throughput: one request per clock while full is low, set by the front
//   stage and the fully pipelined three-stage back end.
//   A queue between the front and back parts lets each stall on its own.
//   When the receiver stalls, results collect in the output queue, the back
//   pipeline holds, then the middle queue fills and full rises.
//   Reset: all queues empty, saturation 255, lightness 128.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hsl_to_rgb_converter import h2r_pkg::*; #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output      logic               full,
  input  wire logic signed [31:0] hue_i,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [7:0]         red_o,
  output      logic [7:0]         green_o,
  output      logic [7:0]         blue_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i
);

  logic [7:0] sat_q;
  logic [7:0] light_q;
  h2r_cfg_t   cfg;

  h2r_item_t  front_item;
  logic       mid_push;
  logic       mid_full;
  h2r_item_t  mid_item;
  logic       mid_empty;
  logic       mid_pop;

  logic       out_push;
  logic       out_full;
  logic [7:0] back_red, back_green, back_blue;
  logic [23:0] out_data;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q   <= 8'd255;
      light_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSaturation: sat_q   <= cfg_data_i;
        RegLightness:  light_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.sat   = sat_q;
  assign cfg.light = light_q;

  h2r_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .hue_i        (hue_i),
    .full         (full),
    .item_o       (front_item),
    .item_push_o  (mid_push),
    .queue_full_i (mid_full)
  );

  h2r_fifo #(
    .WIDTH ($bits(h2r_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_item),
    .empty_o (mid_empty)
  );

  h2r_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (mid_item),
    .item_empty_i (mid_empty),
    .item_pop_o   (mid_pop),
    .rgb_push_o   (out_push),
    .red_o        (back_red),
    .green_o      (back_green),
    .blue_o       (back_blue),
    .rgb_full_i   (out_full)
  );

  h2r_fifo #(
    .WIDTH (24),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({back_red, back_green, back_blue}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign red_o   = out_data[23:16];
  assign green_o = out_data[15:8];
  assign blue_o  = out_data[7:0];

  // Internal queues are never written while full
  `H2R_ASSERT_NEVER(a_mid_overflow, mid_push && mid_full, "middle queue overflow")
  `H2R_ASSERT_NEVER(a_out_overflow, out_push && out_full, "output queue overflow")
  // Classified hue stays inside the circle
  `H2R_ASSERT(a_item_range, mid_push |-> (front_item.sector <= 3'd5) && (front_item.rem < 6'd60), "hue classification out of range")
  // Back end pops only from a non-empty queue
  `H2R_ASSERT_NEVER(a_pop_empty, mid_pop && mid_empty, "pop from empty middle queue")

endmodule

`default_nettype wire

// ----- tb/sv/hsl_to_rgb_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_tb
// Self-checking bench for the fixed-point HSL to RGB converter. A table of
// directed hues and register settings runs first, then random hues in bursts
// under several saturation/lightness settings. Every accepted request is
// predicted from the table or an independent fixed-point model; popped
// colors are compared by channel, in order, while the sink stalls at random.
// ----------------------------------------------------------------------------

module hsl_to_rgb_converter_tb;
  import h2r_pkg::*;

  // Fixed-point constants of the predictor
  localparam longint QOne    = 65536;
  localparam longint HueTurn = 360 * 65536;
  localparam int     DirRows = 29;
  localparam int     Phases  = 10;
  localparam int     PhaseItems = 45;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {ROW_HUE, ROW_SAT, ROW_LIGHT} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        known;
    rgb_t        rgb;
  } stim_row_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_HOLD} sink_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [31:0] hue_i;
  logic               empty;
  logic               pop;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [7:0]         cfg_data_i;

  // Predictor copy of the registers, and colors still owed by the block
  logic [7:0] sat_cfg;
  logic [7:0] light_cfg;
  rgb_t       expected_pixels [$];
  int         mismatch_cnt;

  // Directed hues and register writes; known colors hold for the setting in force
  stim_row_t dir_rows [DirRows] = '{
    '{ROW_HUE,   32'h0000_0000, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{ROW_HUE,   32'h003C_0000, 1'b1, '{8'd255, 8'd255, 8'd0  }},
    '{ROW_HUE,   32'h0078_0000, 1'b1, '{8'd0,   8'd255, 8'd0  }},
    '{ROW_HUE,   32'h00B4_0000, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{ROW_HUE,   32'h00F0_0000, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{ROW_HUE,   32'h012C_0000, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{ROW_HUE,   32'h0168_0000, 1'b1, '{8'd255, 8'd0,   8'd0  }},
    '{ROW_HUE,   32'hFF88_0000, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{ROW_HUE,   32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_HUE,   32'h8000_0000, 1'b0, '0},
    '{ROW_HUE,   32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_HUE,   32'h0167_FFFF, 1'b0, '0},
    '{ROW_HUE,   32'h003B_FFFF, 1'b0, '0},
    '{ROW_HUE,   32'h001E_8000, 1'b0, '0},
    '{ROW_HUE,   32'h00D2_4000, 1'b0, '0},
    '{ROW_LIGHT, 32'h0000_0000, 1'b0, '0},
    '{ROW_HUE,   32'h0014_0000, 1'b1, '{8'd0,   8'd0,   8'd0  }},
    '{ROW_LIGHT, 32'h0000_00FF, 1'b0, '0},
    '{ROW_HUE,   32'h00C8_0000, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{ROW_LIGHT, 32'h0000_0080, 1'b0, '0},
    '{ROW_SAT,   32'h0000_0000, 1'b0, '0},
    '{ROW_HUE,   32'h005A_0000, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{ROW_SAT,   32'h0000_0080, 1'b0, '0},
    '{ROW_LIGHT, 32'h0000_0040, 1'b0, '0},
    '{ROW_HUE,   32'h0028_0000, 1'b0, '0},
    '{ROW_HUE,   32'hFFFF_0000, 1'b0, '0},
    '{ROW_SAT,   32'h0000_00FF, 1'b0, '0},
    '{ROW_LIGHT, 32'h0000_00BF, 1'b0, '0},
    '{ROW_HUE,   32'h0104_0000, 1'b0, '0}
  };

  hsl_to_rgb_converter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .hue_i      (hue_i),
    .empty      (empty),
    .pop        (pop),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Q16.16 channel level to 8 bits, clamped at both ends
  function automatic logic [7:0] to_chan8(longint level);
    longint scaled;
    if (level <= 0) begin
      return 8'd0;
    end
    scaled = (level * 255) / QOne;
    if (scaled > 255) begin
      scaled = 255;
    end
    return scaled[7:0];
  endfunction

  // Expected color for one hue under the given saturation and lightness
  function automatic rgb_t hsl_pixel(logic signed [31:0] hue, logic [7:0] sat,
                                     logic [7:0] light);
    longint deg, s_q, l_q, span, chroma, hprime, tri_w, second, base;
    longint r, g, b;
    int     sector;
    rgb_t   px;
    // wrap into [0, 360) degrees, true modulus
    deg = longint'(hue);
    deg = deg % HueTurn;
    if (deg < 0) begin
      deg = deg + HueTurn;
    end
    s_q = (longint'(sat) * QOne) / 255;
    l_q = (longint'(light) * QOne) / 255;
    span = 2 * l_q - QOne;
    if (span < 0) begin
      span = -span;
    end
    chroma = ((QOne - span) * s_q) / QOne;
    hprime = (deg / 60) % (2 * QOne);
    tri_w = hprime - QOne;
    if (tri_w < 0) begin
      tri_w = -tri_w;
    end
    second = (chroma * (QOne - tri_w)) / QOne;
    base = l_q - chroma / 2;
    sector = int'((deg / QOne) / 60);
    case (sector)
      0: begin r = chroma; g = second; b = 0;      end
      1: begin r = second; g = chroma; b = 0;      end
      2: begin r = 0;      g = chroma; b = second; end
      3: begin r = 0;      g = second; b = chroma; end
      4: begin r = second; g = 0;      b = chroma; end
      default: begin r = chroma; g = 0; b = second; end
    endcase
    px.red   = to_chan8(r + base);
    px.green = to_chan8(g + base);
    px.blue  = to_chan8(b + base);
    return px;
  endfunction

  // Random hue: full range, within three turns of zero, near a sector edge, or negative
  function automatic logic [31:0] pick_hue();
    int deg;
    int frac;
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: begin
        deg = int'($urandom_range(2160, 0)) - 1080;
        frac = int'($urandom_range(65535, 0));
        return 32'(deg * 65536 + frac);
      end
      2: begin
        deg = (int'($urandom_range(18, 0)) - 6) * 60;
        return 32'(deg * 65536 + int'($urandom_range(4, 0)) - 2);
      end
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  function automatic void check_chan(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Offer one request and hold it until taken, then record its color
  task automatic send_hue(logic signed [31:0] hue, logic known, rgb_t want);
    @(negedge clk_i);
    push  <= 1'b1;
    hue_i <= hue;
    do @(posedge clk_i); while (full);
    expected_pixels.push_back(known ? want : hsl_pixel(hue, sat_cfg, light_cfg));
  endtask

  // Drop push for a gap of the given length
  task automatic rest_sender(int cycles);
    @(negedge clk_i);
    push  <= 1'b0;
    hue_i <= $urandom;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Hold the sender until every owed color has been popped
  task automatic settle_results();
    rest_sender(1);
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegSaturation) begin
      sat_cfg = data;
    end else begin
      light_cfg = data;
    end
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(3, 0))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // Sender: directed table, then random phases in bursts
  initial begin
    int remaining;
    int blen;
    bit steady;
    push         = 1'b0;
    hue_i        = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegSaturation;
    cfg_data_i   = '0;
    rst_ni       = 1'b0;
    sat_cfg      = 8'd255;
    light_cfg    = 8'd128;
    mismatch_cnt = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed table, settling before each register write
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_HUE: send_hue(dir_rows[i].value, dir_rows[i].known, dir_rows[i].rgb);
        ROW_SAT: begin
          settle_results();
          write_reg(RegSaturation, dir_rows[i].value[7:0]);
        end
        default: begin
          settle_results();
          write_reg(RegLightness, dir_rows[i].value[7:0]);
        end
      endcase
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < Phases; ph++) begin
      settle_results();
      write_reg(RegSaturation, pick_level());
      write_reg(RegLightness, pick_level());
      steady = (ph % 3 == 1);
      remaining = PhaseItems;
      while (remaining > 0) begin
        blen = int'($urandom_range(12, 1));
        if (blen > remaining) begin
          blen = remaining;
        end
        repeat (blen) send_hue(pick_hue(), 1'b0, '0);
        remaining -= blen;
        if (!steady && $urandom_range(3, 0) != 0) begin
          rest_sender(int'($urandom_range(8, 1)));
        end
      end
    end

    // let the pipeline empty, then give stray results time to show
    settle_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Sink: stall pattern picked afresh each time win_cnt wraps to zero
  initial begin
    sink_mode_e mode;
    int         win_cnt;
    pop     = 1'b0;
    win_cnt = 0;
    mode    = SINK_FREE;
    forever begin
      @(negedge clk_i);
      if (win_cnt == 0) begin
        mode = sink_mode_e'($urandom_range(3, 0));
      end
      case (mode)
        SINK_FREE:   pop <= 1'b1;
        SINK_COIN:   pop <= 1'($urandom_range(1, 0));
        SINK_SPARSE: pop <= (win_cnt % 4 == 0);
        default:     pop <= (win_cnt >= 30);
      endcase
      win_cnt = (win_cnt + 1) % 40;
    end
  end

  // Compare each popped color with the oldest owed one
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", red_o, green_o, blue_o);
        mismatch_cnt++;
      end else begin
        want = expected_pixels.pop_front();
        check_chan("red", want.red, red_o);
        check_chan("green", want.green, green_o);
        check_chan("blue", want.blue, blue_o);
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
